@@ sv/cel_pkg.sv @@
// Shared types, codes and text tables for the console escape line editor.
// No dependencies; the top level, front, queue and back files use this package.
package cel_pkg;

   // Control characters seen on the console.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h14;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // Result destinations.
   localparam logic [1:0] DEST_CONSOLE = 2'd0;
   localparam logic [1:0] DEST_LINK    = 2'd1;
   localparam logic [1:0] DEST_LINE    = 2'd2;

   // Queue operations.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_STATUS = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ON         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_MODE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_CONTROL_ON = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RTS_HOLD_LEVEL  = 3'd4;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [7:0] LINE_LIMIT_RESET = 8'd80;

   // Job kinds passed from the front to the back.
   localparam logic [2:0] KIND_STATUS  = 3'd0;  // single status-only item
   localparam logic [2:0] KIND_LINK    = 3'd1;  // forward byte to the link
   localparam logic [2:0] KIND_LINE    = 3'd2;  // optional echo, then line append
   localparam logic [2:0] KIND_ERASE   = 3'd3;  // line remove, optional erase echo
   localparam logic [2:0] KIND_ESC_FWD = 3'd4;  // link escape, optional prompt wipe
   localparam logic [2:0] KIND_PROMPT  = 3'd5;  // flush, prompt, optional slave notice

   // Decoupling queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [3:0] last_idx;
      logic       cmd_request;
      logic       tx_enable;
      logic       rts_drive;
      logic       rts_level;
   } job_type;

   typedef struct packed {
      logic [1:0] dest;
      logic [1:0] op;
      logic [7:0] data;
   } item_type;

   // Echo that wipes the prompt after a doubled escape: BS BS space, four
   // times, then one BS. Position 0 is the link item.
   function automatic logic [7:0] erase_echo_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd3, 4'd6, 4'd9, 4'd12: c = CH_SPACE;
         default:                 c = CH_BS;
      endcase
      return c;
   endfunction

   // Prompt text at positions 1..7, slave notice at 8..15.
   function automatic logic [7:0] prompt_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd1:    c = CH_CR;
         4'd2:    c = CH_NL;
         4'd3:    c = 8'h4D;
         4'd4:    c = 8'h53;
         4'd5:    c = 8'h43;
         4'd6:    c = 8'h3E;
         4'd7:    c = CH_SPACE;
         4'd8:    c = 8'h53;
         4'd9:    c = 8'h6C;
         4'd10:   c = 8'h61;
         4'd11:   c = 8'h76;
         4'd12:   c = 8'h65;
         4'd13:   c = 8'h21;
         4'd14:   c = CH_CR;
         4'd15:   c = CH_NL;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Item at position idx of a job.
   function automatic item_type job_item(input job_type job, input logic [3:0] idx);
      item_type it;
      it.dest = DEST_CONSOLE;
      it.op   = OP_APPEND;
      it.data = 8'h00;
      unique case (job.kind)
         KIND_LINK: begin
            it.dest = DEST_LINK;
            it.data = job.ch;
         end
         KIND_LINE: begin
            if (idx == job.last_idx) begin
               it.dest = DEST_LINE;
               it.data = job.ch;
            end else if (idx == 4'd0) begin
               it.data = job.ch;
            end else begin
               it.data = CH_NL;
            end
         end
         KIND_ERASE: begin
            if (idx == 4'd0) begin
               it.dest = DEST_LINE;
               it.op   = OP_REMOVE;
            end else if (idx == 4'd2) begin
               it.data = CH_SPACE;
            end else begin
               it.data = CH_BS;
            end
         end
         KIND_ESC_FWD: begin
            if (idx == 4'd0) begin
               it.dest = DEST_LINK;
               it.data = CH_ESC;
            end else begin
               it.data = erase_echo_char(idx);
            end
         end
         KIND_PROMPT: begin
            if (idx == 4'd0) begin
               it.op = OP_FLUSH;
            end else begin
               it.data = prompt_char(idx);
            end
         end
         default: begin
            it.op = OP_STATUS;
         end
      endcase
      return it;
   endfunction

endpackage

@@ sv/cel_req_if.sv @@
// Input channel of the console escape line editor: one received byte and
// the two queue lengths. Depends on nothing.
interface cel_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] line_queue_len;
   logic [7:0] link_queue_len;

   modport source (output valid, output rx_byte, output line_queue_len,
                   output link_queue_len, input ready);
   modport sink   (input valid, input rx_byte, input line_queue_len,
                   input link_queue_len, output ready);
endinterface

@@ sv/cel_rsp_if.sv @@
// Result channel of the console escape line editor: one queue operation
// with its status flags. Depends on nothing.
interface cel_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] dest;
   logic [1:0] op;
   logic [7:0] data;
   logic       last;
   logic       cmd_request;
   logic       tx_enable;
   logic       rts_drive;
   logic       rts_level;

   modport source (output valid, output dest, output op, output data, output last,
                   output cmd_request, output tx_enable, output rts_drive,
                   output rts_level, input ready);
   modport sink   (input valid, input dest, input op, input data, input last,
                   input cmd_request, input tx_enable, input rts_drive,
                   input rts_level, output ready);
endinterface

@@ sv/console_escape_line_editor.sv @@
// Console escape line editor, top level.
// Registers on a byte's path: job queue, back-end job register, output register.
// Throughput: one result item per cycle from the back end while the output is not
// stalled; a byte producing n items (1 to 16) holds the back end until its last item, stepped by the item counter.
// A two-entry job queue lets the front accept bytes while the back still works.
// Reset (synchronous): pass-through mode, escape flag clear, registers to defaults.
module console_escape_line_editor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [cel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cel_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   cel_req_if.sink                         req_bus,
   cel_rsp_if.source                       rsp_bus
);

   logic             f_valid, f_ready;
   cel_pkg::job_type f_job;
   logic             b_valid, b_ready;
   cel_pkg::job_type b_job;

   cel_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .job_valid   (f_valid),
      .job_ready   (f_ready),
      .job         (f_job)
   );

   cel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_job   (b_job)
   );

   cel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (b_valid),
      .job_ready (b_ready),
      .job_in    (b_job),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ sv/cel_front.sv @@
// Front end: configuration registers, mode state and classification of
// each received byte into a job. Depends on cel_pkg and cel_req_if.
module cel_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [cel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cel_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   cel_req_if.sink                         req_bus,
   output logic                            job_valid,
   input  logic                            job_ready,
   output cel_pkg::job_type                job
);

   logic       echo_on_ff, slave_mode_ff, flow_on_ff, hold_level_ff;
   logic [7:0] line_limit_ff;
   logic       pass_ff, pass_in;
   logic       esc_seen_ff, esc_seen_in;
   logic       push;
   logic       is_term, is_erase, check_flow;
   logic [8:0] len_after;
   logic [7:0] ch;

   assign ch             = req_bus.rx_byte;
   assign req_bus.ready  = job_ready;
   assign job_valid      = req_bus.valid;
   assign push           = req_bus.valid && job_ready;

   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_on_ff    <= 1'b0;
         slave_mode_ff <= 1'b0;
         line_limit_ff <= cel_pkg::LINE_LIMIT_RESET;
         flow_on_ff    <= 1'b0;
         hold_level_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cel_pkg::CSR_ECHO_ON:         echo_on_ff    <= csr_wr_data[0];
            cel_pkg::CSR_SLAVE_MODE:      slave_mode_ff <= csr_wr_data[0];
            cel_pkg::CSR_LINE_LIMIT:      line_limit_ff <= csr_wr_data[7:0];
            cel_pkg::CSR_FLOW_CONTROL_ON: flow_on_ff    <= csr_wr_data[0];
            cel_pkg::CSR_RTS_HOLD_LEVEL:  hold_level_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Classify the byte and work out the next mode.
   always_comb begin
      is_term  = (ch == cel_pkg::CH_NUL) || (ch == cel_pkg::CH_NL) ||
                 (ch == cel_pkg::CH_CR);
      is_erase = (ch == cel_pkg::CH_BS) || (ch == cel_pkg::CH_DEL);
      pass_in     = pass_ff;
      esc_seen_in = esc_seen_ff;
      check_flow  = 1'b0;
      len_after   = {1'b0, req_bus.line_queue_len};
      job.kind        = cel_pkg::KIND_STATUS;
      job.ch          = ch;
      job.last_idx    = 4'd0;
      job.cmd_request = 1'b0;
      job.tx_enable   = 1'b0;
      if (!pass_ff) begin
         if (ch == cel_pkg::CH_ESC && esc_seen_ff) begin
            // doubled escape: forward one escape and, with echo on, wipe the prompt
            job.kind      = cel_pkg::KIND_ESC_FWD;
            job.last_idx  = echo_on_ff ? 4'd13 : 4'd0;
            job.tx_enable = echo_on_ff;
            pass_in       = 1'b1;
            esc_seen_in   = 1'b0;
         end else begin
            job.cmd_request = is_term;
            check_flow      = 1'b1;
            if (is_term) begin
               pass_in = 1'b1;
            end
            if (is_erase) begin
               if (req_bus.line_queue_len != 8'd0) begin
                  job.kind      = cel_pkg::KIND_ERASE;
                  job.last_idx  = echo_on_ff ? 4'd3 : 4'd0;
                  job.tx_enable = echo_on_ff;
                  len_after     = {1'b0, req_bus.line_queue_len} - 9'd1;
               end
            end else begin
               job.kind      = cel_pkg::KIND_LINE;
               job.tx_enable = echo_on_ff;
               if (!echo_on_ff) begin
                  job.last_idx = 4'd0;
               end else if (ch == cel_pkg::CH_CR) begin
                  job.last_idx = 4'd2;
               end else begin
                  job.last_idx = 4'd1;
               end
               len_after = {1'b0, req_bus.line_queue_len} + 9'd1;
            end
         end
      end else if (ch == cel_pkg::CH_ESC) begin
         // enter command mode; slave mode with echo falls straight back
         pass_in     = 1'b0;
         esc_seen_in = 1'b1;
         if (echo_on_ff) begin
            job.kind      = cel_pkg::KIND_PROMPT;
            job.last_idx  = slave_mode_ff ? 4'd15 : 4'd7;
            job.tx_enable = 1'b1;
            if (slave_mode_ff) begin
               pass_in = 1'b1;
            end
         end
      end else begin
         job.kind    = cel_pkg::KIND_LINK;
         esc_seen_in = 1'b0;
         check_flow  = 1'b1;
         len_after   = {1'b0, req_bus.link_queue_len} + 9'd1;
      end
      job.rts_drive = check_flow && flow_on_ff && (len_after >= {1'b0, line_limit_ff});
      job.rts_level = job.rts_drive && hold_level_ff;
   end

   // Advance the mode state on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff     <= 1'b1;
         esc_seen_ff <= 1'b0;
      end else if (push) begin
         pass_ff     <= pass_in;
         esc_seen_ff <= esc_seen_in;
      end
   end

endmodule

@@ sv/cel_queue.sv @@
// Short job queue that decouples the front from the back.
// Depends on cel_pkg.
module cel_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cel_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output cel_pkg::job_type out_job
);

   cel_pkg::job_type              mem_ff [cel_pkg::QUEUE_DEPTH];
   logic [cel_pkg::QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [cel_pkg::QUEUE_AW:0]    count_ff;
   logic                          push, pop;

   assign in_ready  = (count_ff < (cel_pkg::QUEUE_AW+1)'(cel_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Store entries.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

   // Advance pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/cel_back.sv @@
// Back end: expands each job into result items, one per cycle while the output
// register is free, into that register. Depends on cel_pkg and cel_rsp_if.
module cel_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  cel_pkg::job_type job_in,
   cel_rsp_if.source        rsp_bus
);

   cel_pkg::job_type  job_ff;
   logic              busy_ff;
   logic [3:0]        idx_ff;
   logic              out_vld_ff, out_vld_in;
   logic              out_free, fire, fin, load;
   cel_pkg::item_type item;
   logic [1:0]        dest_ff;
   logic [1:0]        op_ff;
   logic [7:0]        data_ff;
   logic              last_ff, cmd_ff, tx_ff, rts_ff, lvl_ff;

   assign out_free  = !out_vld_ff || rsp_bus.ready;
   assign fire      = busy_ff && out_free;
   assign fin       = fire && (idx_ff == job_ff.last_idx);
   assign job_ready = !busy_ff || fin;
   assign load      = job_valid && job_ready;
   assign item      = cel_pkg::job_item(job_ff, idx_ff);

   always_comb begin
      out_vld_in = out_vld_ff;
      if (fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Hold the current job and step through its items.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         idx_ff     <= 4'd0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= 4'd0;
         end else if (fin) begin
            busy_ff <= 1'b0;
         end else if (fire) begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   // Capture the job payload.
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_in;
      end
   end

   // Load the output register; flags ride on the last item only.
   always_ff @(posedge clock) begin
      if (fire) begin
         dest_ff <= item.dest;
         op_ff   <= item.op;
         data_ff <= item.data;
         last_ff <= fin;
         cmd_ff  <= fin && job_ff.cmd_request;
         tx_ff   <= fin && job_ff.tx_enable;
         rts_ff  <= fin && job_ff.rts_drive;
         lvl_ff  <= fin && job_ff.rts_level;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.dest        = dest_ff;
   assign rsp_bus.op          = op_ff;
   assign rsp_bus.data        = data_ff;
   assign rsp_bus.last        = last_ff;
   assign rsp_bus.cmd_request = cmd_ff;
   assign rsp_bus.tx_enable   = tx_ff;
   assign rsp_bus.rts_drive   = rts_ff;
   assign rsp_bus.rts_level   = lvl_ff;

endmodule
